// ===== hdl/dtoid_pkg.sv =====
package dtoid_pkg;

    localparam int LISTS_W = 5;

    // Configuration register indexes.
    localparam logic [1:0] REG_ID_FORM      = 2'd0;
    localparam logic [1:0] REG_WORD_ORDER   = 2'd1;
    localparam logic [1:0] REG_STAMP_BYTES  = 2'd2;
    localparam logic [1:0] REG_LISTS_IN_USE = 2'd3;

    // Item modes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Identification field size of each form, which is also its minimum length.
    localparam logic [3:0] OFF_ABS         = 4'd1;
    localparam logic [3:0] OFF_REL_BYTE    = 4'd2;
    localparam logic [3:0] OFF_REL_WORD    = 4'd3;
    localparam logic [3:0] OFF_REL_ALIGNED = 4'd4;

    typedef enum logic [1:0] {
        FORM_ABS,
        FORM_REL_BYTE,
        FORM_REL_WORD,
        FORM_REL_ALIGNED
    } dtoid_form_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FETCH,
        BK_RESULT
    } dtoid_back_state_t;

    typedef struct packed {
        dtoid_form_t        form;
        logic               word_order;
        logic [2:0]         stamp_bytes;
        logic [LISTS_W-1:0] lists_in_use;
    } dtoid_cfg_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic        is_load;
        logic [3:0]  entry_index;
        logic [7:0]  base_pid;
        logic [7:0]  odt_count;
        logic        pid_off;
        logic        stamped;
        logic [15:0] pdu;
        logic [7:0]  frame_length;
        logic [7:0]  b0;
        logic        abs_en;
        logic        rel_dec;
        logic [15:0] rel_list;
        logic [3:0]  base_off;
    } dtoid_item_t;

    function automatic logic [2:0] stamp_size(input logic [2:0] code);
        logic [2:0] size;
        unique case (code) inside
            3'd1, 3'd2, 3'd4: size = code;
            default:          size = 3'd0;
        endcase
        return size;
    endfunction

endpackage

// ===== hdl/dtoid_front.sv =====
module dtoid_front (
    input  dtoid_pkg::dtoid_cfg_t  cfg,
    input  logic                   s_mode,
    input  logic [3:0]             s_entry_index,
    input  logic [7:0]             s_entry_base_pid,
    input  logic [7:0]             s_entry_odt_count,
    input  logic                   s_entry_pid_off,
    input  logic                   s_entry_stamped,
    input  logic [15:0]            s_pdu_id,
    input  logic [7:0]             s_frame_length,
    input  logic [7:0]             s_byte_zero,
    input  logic [7:0]             s_byte_one,
    input  logic [7:0]             s_byte_two,
    input  logic [7:0]             s_byte_three,
    output dtoid_pkg::dtoid_item_t item
);
    import dtoid_pkg::*;

    logic [15:0] word_mid;
    logic [15:0] word_high;

    // The list number word, in the configured byte order.
    assign word_mid  = cfg.word_order ? {s_byte_one, s_byte_two} : {s_byte_two, s_byte_one};
    assign word_high = cfg.word_order ? {s_byte_two, s_byte_three}
                                      : {s_byte_three, s_byte_two};

    always_comb begin
        item.is_load      = (s_mode == MODE_LOAD);
        item.entry_index  = s_entry_index;
        item.base_pid     = s_entry_base_pid;
        item.odt_count    = s_entry_odt_count;
        item.pid_off      = s_entry_pid_off;
        item.stamped      = s_entry_stamped;
        item.pdu          = s_pdu_id;
        item.frame_length = s_frame_length;
        item.b0           = s_byte_zero;
        item.abs_en       = 1'b0;
        item.rel_dec      = 1'b0;
        item.rel_list     = '0;
        item.base_off     = OFF_ABS;
        unique case (cfg.form)
            FORM_ABS: begin
                item.abs_en   = (s_frame_length >= 8'(OFF_ABS));
                item.base_off = OFF_ABS;
            end
            FORM_REL_BYTE: begin
                item.rel_dec  = (s_frame_length >= 8'(OFF_REL_BYTE));
                item.rel_list = {8'd0, s_byte_one};
                item.base_off = OFF_REL_BYTE;
            end
            FORM_REL_WORD: begin
                item.rel_dec  = (s_frame_length >= 8'(OFF_REL_WORD));
                item.rel_list = word_mid;
                item.base_off = OFF_REL_WORD;
            end
            FORM_REL_ALIGNED: begin
                item.rel_dec  = (s_frame_length >= 8'(OFF_REL_ALIGNED));
                item.rel_list = word_high;
                item.base_off = OFF_REL_ALIGNED;
            end
        endcase
    end

endmodule

// ===== hdl/dtoid_queue.sv =====
module dtoid_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dtoid_pkg::dtoid_item_t in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dtoid_pkg::dtoid_item_t out_item
);
    import dtoid_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    dtoid_item_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != DEPTH);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/dtoid_back.sv =====
module dtoid_back #(
    parameter int MAX_LISTS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dtoid_pkg::dtoid_cfg_t  cfg,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  dtoid_pkg::dtoid_item_t q_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_decoded_ok,
    output logic [7:0]             m_list_number,
    output logic [7:0]             m_rel_odt,
    output logic [3:0]             m_payload_offset
);
    import dtoid_pkg::*;

    localparam int IDX_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int CNT_W = $clog2(MAX_LISTS + 1);
    localparam int LIM_W = (CNT_W > LISTS_W) ? CNT_W : LISTS_W;

    typedef struct packed {
        logic [15:0] pdu;
        logic [7:0]  odt_count;
        logic [7:0]  base_pid;
    } dtoid_entry_t;

    dtoid_entry_t      entry_mem [MAX_LISTS];
    dtoid_entry_t      rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;

    logic [MAX_LISTS-1:0] pid_off_reg, pid_off_next;
    logic [MAX_LISTS-1:0] stamped_reg, stamped_next;

    dtoid_back_state_t state_reg, state_next;
    dtoid_item_t       item_reg, item_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic [IDX_W-1:0]  chk_reg, chk_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              dec_reg, dec_next;
    logic [7:0]        list_reg, list_next;
    logic [7:0]        odt_reg, odt_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic              stmp_reg, stmp_next;
    logic [3:0]        base_reg, base_next;

    logic              m_valid_reg, m_valid_next;
    logic              ok_reg, ok_next;
    logic [7:0]        out_list_reg, out_list_next;
    logic [7:0]        out_odt_reg, out_odt_next;
    logic [3:0]        out_off_reg, out_off_next;

    logic [CNT_W-1:0]  live_n;
    logic              issue;
    logic              scan_end;
    logic              off_hit;
    logic              abs_hit;
    logic              rel_hit;
    logic              out_free;
    logic              load_in_range;
    logic [8:0]        range_hi;
    logic [2:0]        stamp_add;
    logic [3:0]        total_off;
    logic              result_ok;

    assign live_n = (LIM_W'(cfg.lists_in_use) > LIM_W'(MAX_LISTS)) ? CNT_W'(MAX_LISTS)
                                                                    : CNT_W'(cfg.lists_in_use);

    assign q_ready  = (state_reg == BK_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign load_in_range = ({4'd0, q_item.entry_index} < 8'(MAX_LISTS));
    assign wr_en   = (state_reg == BK_IDLE) && q_valid && q_item.is_load && load_in_range;
    assign wr_addr = IDX_W'(q_item.entry_index);

    // The scan issues one table read a cycle and checks each entry in the cycle after its read.
    assign issue    = (state_reg == BK_SCAN) && (iss_reg < live_n);
    assign scan_end = (state_reg == BK_SCAN) && !issue;
    assign rel_hit  = item_reg.rel_dec && (item_reg.rel_list < 16'(live_n));

    assign range_hi = {1'b0, rd_data_reg.base_pid} + {1'b0, rd_data_reg.odt_count};
    assign off_hit  = (state_reg == BK_SCAN) && chk_vld_reg && pid_off_reg[chk_reg]
                      && (rd_data_reg.pdu == item_reg.pdu);
    assign abs_hit  = (state_reg == BK_SCAN) && chk_vld_reg && item_reg.abs_en && !dec_reg
                      && (item_reg.b0 >= rd_data_reg.base_pid)
                      && ({1'b0, item_reg.b0} < range_hi);

    // ODT 0 of a stamped list carries the timestamp after the id field.
    assign stamp_add = ((odt_reg == 8'd0) && stmp_reg) ? stamp_size(cfg.stamp_bytes) : 3'd0;
    assign total_off = base_reg + {1'b0, stamp_add};
    assign result_ok = dec_reg && (odt_reg < cnt_reg)
                       && (item_reg.frame_length >= {4'd0, total_off});

    always_comb begin
        rd_addr = '0;
        if (issue) begin
            rd_addr = iss_reg[IDX_W-1:0];
        end else if (scan_end && rel_hit) begin
            rd_addr = item_reg.rel_list[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= '{pdu: q_item.pdu, odt_count: q_item.odt_count,
                                   base_pid: q_item.base_pid};
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && !q_item.is_load) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (off_hit) begin
                    state_next = BK_RESULT;
                end else if (scan_end) begin
                    state_next = rel_hit ? BK_FETCH : BK_RESULT;
                end
            end
            BK_FETCH: begin
                state_next = BK_RESULT;
            end
            BK_RESULT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        item_next     = item_reg;
        iss_next      = iss_reg;
        chk_next      = chk_reg;
        chk_vld_next  = 1'b0;
        dec_next      = dec_reg;
        list_next     = list_reg;
        odt_next      = odt_reg;
        cnt_next      = cnt_reg;
        stmp_next     = stmp_reg;
        base_next     = base_reg;
        pid_off_next  = pid_off_reg;
        stamped_next  = stamped_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ok_next       = ok_reg;
        out_list_next = out_list_reg;
        out_odt_next  = out_odt_reg;
        out_off_next  = out_off_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (wr_en) begin
                    pid_off_next[wr_addr] = q_item.pid_off;
                    stamped_next[wr_addr] = q_item.stamped;
                end
                if (q_valid && !q_item.is_load) begin
                    item_next = q_item;
                    iss_next  = '0;
                    dec_next  = 1'b0;
                    base_next = q_item.base_off;
                end
            end
            BK_SCAN: begin
                chk_vld_next = issue;
                chk_next     = iss_reg[IDX_W-1:0];
                if (issue) begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (off_hit) begin
                    // A PID-off list on this PDU overrides any range match.
                    dec_next  = 1'b1;
                    list_next = 8'(chk_reg);
                    odt_next  = 8'd0;
                    cnt_next  = rd_data_reg.odt_count;
                    stmp_next = stamped_reg[chk_reg];
                    base_next = 4'd0;
                end else if (abs_hit) begin
                    dec_next  = 1'b1;
                    list_next = 8'(chk_reg);
                    odt_next  = item_reg.b0 - rd_data_reg.base_pid;
                    cnt_next  = rd_data_reg.odt_count;
                    stmp_next = stamped_reg[chk_reg];
                end
                if (!off_hit && scan_end && rel_hit) begin
                    dec_next  = 1'b1;
                    list_next = item_reg.rel_list[7:0];
                    odt_next  = item_reg.b0;
                end
            end
            BK_FETCH: begin
                cnt_next  = rd_data_reg.odt_count;
                stmp_next = stamped_reg[list_reg[IDX_W-1:0]];
            end
            BK_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    ok_next       = result_ok;
                    out_list_next = result_ok ? list_reg : 8'd0;
                    out_odt_next  = result_ok ? odt_reg : 8'd0;
                    out_off_next  = result_ok ? total_off : 4'd0;
                end
            end
            default: begin
                chk_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            pid_off_reg <= '0;
            stamped_reg <= '0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            pid_off_reg <= pid_off_next;
            stamped_reg <= stamped_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        iss_reg      <= iss_next;
        chk_reg      <= chk_next;
        dec_reg      <= dec_next;
        list_reg     <= list_next;
        odt_reg      <= odt_next;
        cnt_reg      <= cnt_next;
        stmp_reg     <= stmp_next;
        base_reg     <= base_next;
        ok_reg       <= ok_next;
        out_list_reg <= out_list_next;
        out_odt_reg  <= out_odt_next;
        out_off_reg  <= out_off_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_decoded_ok     = ok_reg;
    assign m_list_number    = out_list_reg;
    assign m_rel_odt        = out_odt_reg;
    assign m_payload_offset = out_off_reg;

endmodule

// ===== hdl/dto_id_field_decoder.sv =====
// DTO identification field decoder. Load items (mode 0) write one entry of the
// DAQ list table; decode items (mode 1) return one result with the list, the
// relative ODT and the payload offset, or all zeros when the header does not
// decode or fails a bounds or length check. Items pass through a two-entry
// queue to the decode engine, so the input keeps accepting up to two items
// while a decode runs or a result waits to be taken. A load only writes the
// table and leaves the engine idle. A decode scans the lists in use (capped
// at MAX_LISTS); a PID-off list on the frame's PDU ends the scan early. The
// scan over the list table reads one entry a cycle through the table memory's
// single read port. The user must write configuration only while no item is
// in flight; the block itself does not enforce this.
module dto_id_field_decoder #(
    parameter int MAX_LISTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [3:0]  s_entry_index,
    input  logic [7:0]  s_entry_base_pid,
    input  logic [7:0]  s_entry_odt_count,
    input  logic        s_entry_pid_off,
    input  logic        s_entry_stamped,
    input  logic [15:0] s_pdu_id,
    input  logic [7:0]  s_frame_length,
    input  logic [7:0]  s_byte_zero,
    input  logic [7:0]  s_byte_one,
    input  logic [7:0]  s_byte_two,
    input  logic [7:0]  s_byte_three,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_decoded_ok,
    output logic [7:0]  m_list_number,
    output logic [7:0]  m_rel_odt,
    output logic [3:0]  m_payload_offset
);
    import dtoid_pkg::*;

    dtoid_cfg_t  cfg_reg, cfg_next;
    dtoid_item_t front_item;
    dtoid_item_t q_item;
    logic        q_valid;
    logic        q_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ID_FORM:      cfg_next.form         = dtoid_form_t'(cfg_wr_data[1:0]);
                REG_WORD_ORDER:   cfg_next.word_order   = cfg_wr_data[0];
                REG_STAMP_BYTES:  cfg_next.stamp_bytes  = cfg_wr_data[2:0];
                REG_LISTS_IN_USE: cfg_next.lists_in_use = cfg_wr_data[LISTS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{form: FORM_ABS, word_order: 1'b0, stamp_bytes: 3'd0,
                         lists_in_use: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dtoid_front u_front (
        .cfg               (cfg_reg),
        .s_mode            (s_mode),
        .s_entry_index     (s_entry_index),
        .s_entry_base_pid  (s_entry_base_pid),
        .s_entry_odt_count (s_entry_odt_count),
        .s_entry_pid_off   (s_entry_pid_off),
        .s_entry_stamped   (s_entry_stamped),
        .s_pdu_id          (s_pdu_id),
        .s_frame_length    (s_frame_length),
        .s_byte_zero       (s_byte_zero),
        .s_byte_one        (s_byte_one),
        .s_byte_two        (s_byte_two),
        .s_byte_three      (s_byte_three),
        .item              (front_item)
    );

    dtoid_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    dtoid_back #(
        .MAX_LISTS (MAX_LISTS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_decoded_ok     (m_decoded_ok),
        .m_list_number    (m_list_number),
        .m_rel_odt        (m_rel_odt),
        .m_payload_offset (m_payload_offset)
    );

endmodule
